@@ hw/rtl/cnv3_pkg.sv @@
// Shared types and constants for the 3x3 zero-padded convolution filter.
`timescale 1ns / 1ps

package cnv3_pkg;

    localparam int PIXEL_BITS     = 8;
    localparam int SIZE_BITS      = 11;
    localparam int KERNEL_BITS    = 48;
    localparam int COEF_SLOT      = 16;
    localparam int FRAC_BITS      = 12;
    localparam int TAPS           = 3;
    localparam int DRAIN_TRIES    = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [SIZE_BITS-1:0]   RESET_SIZE   = 11'd1024;
    localparam logic [KERNEL_BITS-1:0] RESET_KERNEL = 48'h01C7_01C7_01C7;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH    = 3'd0,
        REG_IMAGE_HEIGHT   = 3'd1,
        REG_KERNEL_ROW_TOP = 3'd2,
        REG_KERNEL_ROW_MID = 3'd3,
        REG_KERNEL_ROW_BOT = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0]              image_width;
        logic [SIZE_BITS-1:0]              image_height;
        logic [TAPS-1:0][KERNEL_BITS-1:0]  kernel;      // [0] is the top row
    } cfg_t;

    typedef struct packed {
        logic                  mode;
        logic [PIXEL_BITS-1:0] pixel;
    } item_t;

    typedef struct packed {
        logic [TAPS-1:0][TAPS-1:0][PIXEL_BITS-1:0] tap;  // [row][column]
        logic                                      last;
    } entry_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] out_pixel;
        logic                  last_of_frame;
    } result_t;

endpackage

@@ hw/rtl/cnv3_stream_if.sv @@
// Valid/ready stream channel carrying one payload per transaction.
`timescale 1ns / 1ps

interface cnv3_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

@@ hw/rtl/cnv3_front.sv @@
// Front end: raster counters, line stores and window; queues 3x3 neighborhoods.
`timescale 1ns / 1ps

module cnv3_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cnv3_pkg::cfg_t       cfg,
    cnv3_stream_if.sink          pixels,
    cnv3_stream_if.source        taps
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 3);
    localparam int PB = cnv3_pkg::PIXEL_BITS;
    localparam int NT = cnv3_pkg::TAPS;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'b01,
        ST_FLUSH  = 2'b10
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [1:0]   steps_reg, steps_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [NT-1:0][PB-1:0] win_mid_reg, win_mid_next;
    logic [NT-1:0][PB-1:0] win_right_reg, win_right_next;

    logic [PB-1:0] upper_mem [MAX_WIDTH];
    logic [PB-1:0] lower_mem [MAX_WIDTH];
    logic [PB-1:0] rd_upper_reg;
    logic [PB-1:0] rd_lower_reg;

    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [RW-1:0] h_p1;
    logic [WW-1:0] x_ext;
    logic [WW-1:0] x_plus;
    logic          x_zero;
    logic          a_ok, b_ok, c_ok;
    logic          accept, adv_pix, adv_drain, flush_step, step;
    logic [PB-1:0] a_px, b_px, c_px;
    logic [NT-1:0][PB-1:0] fresh;
    logic          emit_ok, last, row_adv, restart;
    logic [CW-1:0] col_adv;
    logic [RW-1:0] row_adv_val;

    // Register values outside the legal range are clamped.
    always_comb
    begin
        if (cfg.image_width == '0)
            w_eff = WW'(1);
        else if (32'(cfg.image_width) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(cfg.image_width);

        if (cfg.image_height == '0)
            h_eff = RW'(1);
        else if (32'(cfg.image_height) > 32'(MAX_HEIGHT))
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(cfg.image_height);
    end

    assign h_p1   = h_eff + RW'(1);
    assign x_ext  = WW'(col_reg);
    assign x_plus = x_ext + WW'(1);
    assign x_zero = (col_reg == '0);

    // Row validity of the line-store taps and the incoming pixel.
    assign a_ok = (row_reg > RW'(1)) && (row_reg <= h_p1);
    assign b_ok = (row_reg != '0) && (row_reg <= h_eff);
    assign c_ok = (row_reg < h_eff);

    assign pixels.ready = (state_reg == ST_ACCEPT) && taps.ready;
    assign accept       = pixels.valid && pixels.ready;
    assign adv_pix      = accept && c_ok && (pixels.payload.mode == cnv3_pkg::MODE_PIXEL);
    assign adv_drain    = accept && !c_ok;
    assign flush_step   = (state_reg == ST_FLUSH) && taps.ready;
    assign step         = adv_pix || adv_drain || flush_step;

    assign a_px  = a_ok ? rd_upper_reg : '0;
    assign b_px  = b_ok ? rd_lower_reg : '0;
    assign c_px  = adv_pix ? pixels.payload.pixel : '0;
    assign fresh = {c_px, b_px, a_px};

    // The first column of a row closes the last column of the row before.
    assign emit_ok = x_zero ? a_ok : (b_ok && (x_ext <= w_eff));
    assign last    = x_zero ? (row_reg == h_p1) : ((row_reg == h_eff) && (x_ext == w_eff));

    assign row_adv     = (x_plus >= w_eff);
    assign col_adv     = row_adv ? '0 : x_plus[CW-1:0];
    assign row_adv_val = row_adv ? (row_reg + RW'(1)) : row_reg;
    assign restart     = (emit_ok && last) || (row_adv_val > h_p1);

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        win_mid_next   = win_mid_reg;
        win_right_next = win_right_reg;
        if (step)
        begin
            if (restart)
            begin
                col_next       = '0;
                row_next       = '0;
                win_mid_next   = '0;
                win_right_next = '0;
            end
            else
            begin
                col_next       = col_adv;
                row_next       = row_adv_val;
                win_mid_next   = x_zero ? '0 : win_right_reg;
                win_right_next = fresh;
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < NT; r++)
        begin
            taps.payload.tap[r][0] = win_mid_reg[r];
            taps.payload.tap[r][1] = win_right_reg[r];
            taps.payload.tap[r][2] = x_zero ? '0 : fresh[r];
        end
        taps.payload.last = last;
    end

    assign taps.valid = step && emit_ok;

    // Flush steps follow a resultless drain item until a result or try limit.
    always_comb
    begin
        state_next = state_reg;
        steps_next = steps_reg;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (adv_drain && !emit_ok && !restart)
                begin
                    state_next = ST_FLUSH;
                    steps_next = 2'd1;
                end
            end
            ST_FLUSH:
            begin
                if (flush_step)
                begin
                    if (emit_ok || restart || (steps_reg == 2'(cnv3_pkg::DRAIN_TRIES - 1)))
                        state_next = ST_ACCEPT;
                    else
                        steps_next = steps_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            steps_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            win_mid_reg   <= '0;
            win_right_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            win_mid_reg   <= win_mid_next;
            win_right_reg <= win_right_next;
        end
    end

    // Line stores: write the current column, prefetch the next one.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            upper_mem[col_reg] <= rd_lower_reg;
            lower_mem[col_reg] <= c_px;
        end
        if (step && (col_next == col_reg))
        begin
            rd_upper_reg <= rd_lower_reg;
            rd_lower_reg <= c_px;
        end
        else
        begin
            rd_upper_reg <= upper_mem[col_next];
            rd_lower_reg <= lower_mem[col_next];
        end
    end

endmodule

@@ hw/rtl/cnv3_queue.sv @@
// Short queue of neighborhoods between the front end and the filter datapath.
`timescale 1ns / 1ps

module cnv3_queue (
    input  logic          clk,
    input  logic          rst_n,
    cnv3_stream_if.sink   push,
    cnv3_stream_if.source pop
);

    localparam int DEPTH = cnv3_pkg::QUEUE_DEPTH;
    localparam int PTRW  = cnv3_pkg::QUEUE_PTR_BITS;
    localparam int CNTW  = $clog2(DEPTH + 1);

    cnv3_pkg::entry_t slot_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign push.ready  = (count_reg != CNTW'(DEPTH));
    assign pop.valid   = (count_reg != '0);
    assign pop.payload = slot_reg[rd_ptr_reg];

    assign do_push = push.valid && push.ready;
    assign do_pop  = pop.valid && pop.ready;

    always_comb
    begin
        wr_ptr_next = do_push ? (wr_ptr_reg + PTRW'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + PTRW'(1)) : rd_ptr_reg;
        count_next  = count_reg + CNTW'(do_push) - CNTW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push.payload;
    end

endmodule

@@ hw/rtl/cnv3_back.sv @@
// Filter datapath: nine products, row sums, total, truncation, output register.
`timescale 1ns / 1ps

module cnv3_back #(
    parameter int COEF_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cnv3_pkg::cfg_t cfg,
    cnv3_stream_if.sink    taps,
    cnv3_stream_if.source  results
);

    localparam int PB = cnv3_pkg::PIXEL_BITS;
    localparam int NT = cnv3_pkg::TAPS;
    localparam int FB = cnv3_pkg::FRAC_BITS;
    localparam int PW = COEF_BITS + PB + 1;
    localparam int SW = PW + 4;
    localparam logic [SW-1:0] TRUNC_BIAS = SW'((1 << FB) - 1);

    logic                 en;
    logic                 v1_reg, v2_reg, out_valid_reg;
    logic                 last1_reg, last2_reg;
    logic signed [COEF_BITS-1:0] coef [NT][NT];
    logic signed [PW-1:0] prod_next [NT][NT];
    logic signed [PW-1:0] prod_reg  [NT][NT];
    logic signed [SW-1:0] rsum_next [NT];
    logic signed [SW-1:0] rsum_reg  [NT];
    logic signed [SW-1:0] total;
    logic        [SW-1:0] adj;
    cnv3_pkg::result_t    res_next, res_reg;

    // Advance the whole pipeline whenever the output register can take a value.
    assign en         = !out_valid_reg || results.ready;
    assign taps.ready = en;

    always_comb
    begin
        for (int r = 0; r < NT; r++)
        begin
            for (int c = 0; c < NT; c++)
            begin
                coef[r][c]      = cfg.kernel[r][cnv3_pkg::COEF_SLOT * c +: COEF_BITS];
                prod_next[r][c] = PW'($signed({1'b0, taps.payload.tap[r][c]}))
                                  * PW'(coef[r][c]);
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < NT; r++)
            rsum_next[r] = SW'(prod_reg[r][0]) + SW'(prod_reg[r][1]) + SW'(prod_reg[r][2]);
    end

    // Truncate toward zero: bias negative sums before the arithmetic shift.
    always_comb
    begin
        total = rsum_reg[0] + rsum_reg[1] + rsum_reg[2];
        adj   = total + (total[SW-1] ? TRUNC_BIAS : '0);
        res_next.out_pixel     = adj[FB +: PB];
        res_next.last_of_frame = last2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= taps.valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            last1_reg <= taps.payload.last;
            rsum_reg  <= rsum_next;
            last2_reg <= last1_reg;
            res_reg   <= res_next;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = res_reg;

endmodule

@@ hw/rtl/conv3x3_zero_pad_filter.sv @@
// Top level of the streaming 3x3 zero-padded image convolution filter.
//
// pixels: valid/ready channel of items {mode, pixel}. Pixel items carry the
//   frame in raster order; drain items after the last pixel flush the
//   pending results, at most one result per drain item.
// results: valid/ready channel of {out_pixel, last_of_frame}; last_of_frame
//   marks the final result of a frame, after which a new frame may start.
// cfg_write/cfg_index/cfg_data: register writes, which the user makes only
//   while the block idles; the block itself does not enforce this.
// Throughput: one item per cycle while the queue has room and no flush runs;
//   a one-row frame's first drain item hits an empty window spot; a flush step
//   follows it. With two or more rows, the result for pixel (r, c) leaves the
//   front end with item r*W + c + W + 1, then queue, product, row sum, output.
// Storage: two line stores of MAX_WIDTH x 8 bits, at most one write and one
//   prefetched read each per cycle.
// Reset clears counters, window, queue and pipeline; register defaults are
//   a 1024 x 1024 frame with all coefficients 0x01C7. Line-store contents are
//   not cleared. When results stalls, the pipeline holds, the queue fills and
//   pixels.ready drops; nothing is lost.
`timescale 1ns / 1ps

module conv3x3_zero_pad_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int COEF_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [cnv3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [cnv3_pkg::KERNEL_BITS-1:0]      cfg_data,
    cnv3_stream_if.sink                           pixels,
    cnv3_stream_if.source                         results
);

    cnv3_pkg::cfg_t cfg_reg;

    cnv3_stream_if #(.payload_t(cnv3_pkg::entry_t)) push_q ();
    cnv3_stream_if #(.payload_t(cnv3_pkg::entry_t)) pop_q ();

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= cnv3_pkg::RESET_SIZE;
            cfg_reg.image_height <= cnv3_pkg::RESET_SIZE;
            cfg_reg.kernel       <= {cnv3_pkg::TAPS{cnv3_pkg::RESET_KERNEL}};
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cnv3_pkg::REG_IMAGE_WIDTH:
                    cfg_reg.image_width <= cfg_data[cnv3_pkg::SIZE_BITS-1:0];
                cnv3_pkg::REG_IMAGE_HEIGHT:
                    cfg_reg.image_height <= cfg_data[cnv3_pkg::SIZE_BITS-1:0];
                cnv3_pkg::REG_KERNEL_ROW_TOP:
                    cfg_reg.kernel[0] <= cfg_data;
                cnv3_pkg::REG_KERNEL_ROW_MID:
                    cfg_reg.kernel[1] <= cfg_data;
                cnv3_pkg::REG_KERNEL_ROW_BOT:
                    cfg_reg.kernel[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    cnv3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .pixels (pixels),
        .taps   (push_q)
    );

    cnv3_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push_q),
        .pop   (pop_q)
    );

    cnv3_back #(
        .COEF_BITS (COEF_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .taps    (pop_q),
        .results (results)
    );

endmodule

@@ hw/rtl/cnv3_checker.sv @@
// Port-level checks for the convolution filter, bound to the top level.
`timescale 1ns / 1ps

module cnv3_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input cnv3_pkg::result_t out_data
);

    logic [31:0] pending_reg, pending_next;
    logic        in_xfer, out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // Accepted items minus delivered results; each item yields at most one.
    assign pending_next = pending_reg + 32'(in_xfer) - 32'(out_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> (pending_reg != '0))
        else $error("result transaction without an earlier input transaction");

    a_quiet_in_reset: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result offered during reset");

endmodule

bind conv3x3_zero_pad_filter cnv3_checker u_cnv3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.payload)
);
